/* hdl/multi_tap_delay_line_unit_defines.svh */
// Assertion macros for the multi-tap delay line checker.
// No dependencies; included by the checker file only.
`ifndef MULTI_TAP_DELAY_LINE_UNIT_DEFINES_SVH
`define MULTI_TAP_DELAY_LINE_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante, sampled on aclk, off during reset.
`define MTDLU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons from the cycle after ante.
`define MTDLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mtdl_pkg.sv */
// Shared constants and controller/datapath interface types of the delay line.
// No dependencies.
package mtdl_pkg;

    localparam int DEPTH_FRAMES = 32768;
    localparam int NUM_TAPS     = 4;
    localparam int MAX_CHANNELS = 2;

    localparam int STORE_DEPTH = DEPTH_FRAMES * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FRAME_W     = $clog2(DEPTH_FRAMES);
    localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAP_IDX_W   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    localparam int SAMPLE_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int DELAY_W        = 16;
    localparam int TAP_W          = 33;
    localparam int TAP_ACTIVE_BIT = 32;
    localparam int CNT_W          = 2;
    localparam int FRAC_W         = 14;
    localparam int PROD_W         = SAMPLE_W + GAIN_W;
    localparam int ACC_W          = SAMPLE_W + GAIN_W + $clog2(NUM_TAPS + 1);
    localparam int ROUND_BIAS     = 1 << (FRAC_W - 1);

    localparam int CFG_IDX_W         = $clog2(NUM_TAPS + 2);
    localparam int REG_CHANNEL_COUNT = NUM_TAPS;

    typedef struct packed {
        logic                 clr_write;
        logic                 capture;
        logic                 store_write;
        logic                 tap_read;
        logic                 load_out;
        logic [TAP_IDX_W-1:0] tap_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* hdl/mtdl_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module mtdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hdl/mtdl_ctrl.sv */
// Sequencer of the delay line: clear sweep, store write, tap reads, result load.
// Depends on mtdl_pkg.
module mtdl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mtdl_pkg::dp_stat_t stat,
    output mtdl_pkg::dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [mtdl_pkg::TAP_IDX_W-1:0] tap_cnt_reg, tap_cnt_next;
    logic                           drain_cnt_reg, drain_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tap_cnt_reg   <= '0;
            drain_cnt_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tap_cnt_reg   <= tap_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        tap_cnt_next    = tap_cnt_reg;
        drain_cnt_next  = drain_cnt_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.tap_sel     = tap_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.store_write = 1'b1;
                tap_cnt_next    = '0;
                state_next      = ST_READ;
            end
            ST_READ: begin
                cmd.tap_read = 1'b1;
                if (tap_cnt_reg == mtdl_pkg::TAP_IDX_W'(mtdl_pkg::NUM_TAPS - 1)) begin
                    drain_cnt_next = 1'b0;
                    state_next     = ST_DRAIN;
                end else begin
                    tap_cnt_next = tap_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_cnt_next = 1'b1;
                if (drain_cnt_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/mtdl_datapath.sv */
// Datapath of the delay line: tap registers, frame pointer, store, multiply-accumulate,
// rounding and output register. Depends on mtdl_pkg and mtdl_ram.
module mtdl_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mtdl_pkg::dp_cmd_t                cmd,
    output mtdl_pkg::dp_stat_t               stat,
    input  logic [mtdl_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtdl_pkg::TAP_W-1:0]       cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mtdl_pkg::SAMPLE_W-1:0]    m_tdata
);

    localparam int DIFF_W = mtdl_pkg::DELAY_W + 2;

    logic [mtdl_pkg::TAP_W-1:0]     tap_reg [mtdl_pkg::NUM_TAPS];
    logic [mtdl_pkg::CNT_W-1:0]     chan_cnt_reg;
    logic [mtdl_pkg::FRAME_W-1:0]   frame_reg;
    logic [mtdl_pkg::CH_W-1:0]      chan_idx_reg;
    logic [mtdl_pkg::ADDR_W-1:0]    clr_cnt_reg;
    logic [mtdl_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                           rd_use_reg;
    logic signed [mtdl_pkg::GAIN_W-1:0] rd_gain_reg;
    logic signed [mtdl_pkg::PROD_W-1:0] prod_reg;
    logic signed [mtdl_pkg::ACC_W-1:0]  acc_reg;
    logic                           m_tvalid_reg;
    logic [mtdl_pkg::SAMPLE_W-1:0]  m_tdata_reg;

    logic                           cfg_wr;
    logic [mtdl_pkg::CNT_W-1:0]     cc_eff;
    logic [mtdl_pkg::CH_W-1:0]      ch_eff;
    logic                           last_ch;
    logic [mtdl_pkg::TAP_W-1:0]     tap_sel_word;
    logic [mtdl_pkg::DELAY_W-1:0]   tap_delay;
    logic                           tap_use;
    logic signed [DIFF_W-1:0]       frame_diff;
    logic [mtdl_pkg::FRAME_W-1:0]   read_frame;
    logic [mtdl_pkg::FRAME_W-1:0]   sel_frame;
    logic [mtdl_pkg::ADDR_W-1:0]    item_addr;
    logic                           ram_en;
    logic                           ram_we;
    logic [mtdl_pkg::ADDR_W-1:0]    ram_addr;
    logic [mtdl_pkg::SAMPLE_W-1:0]  ram_wdata;
    logic [mtdl_pkg::SAMPLE_W-1:0]  ram_rdata;
    logic signed [mtdl_pkg::ACC_W-1:0] acc_init;
    logic signed [mtdl_pkg::ACC_W-1:0] acc_rounded;
    logic signed [mtdl_pkg::ACC_W-1:0] acc_scaled;
    logic                           fits;
    logic [mtdl_pkg::SAMPLE_W-1:0]  sat_out;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_comb begin
        if (chan_cnt_reg == '0) begin
            cc_eff = mtdl_pkg::CNT_W'(1);
        end else if (32'(chan_cnt_reg) > mtdl_pkg::MAX_CHANNELS) begin
            cc_eff = mtdl_pkg::CNT_W'(mtdl_pkg::MAX_CHANNELS);
        end else begin
            cc_eff = chan_cnt_reg;
        end
        ch_eff  = (32'(chan_idx_reg) >= 32'(cc_eff)) ? '0 : chan_idx_reg;
        last_ch = (32'(ch_eff) + 1) >= 32'(cc_eff);
    end

    assign tap_sel_word = tap_reg[cmd.tap_sel];
    assign tap_delay    = tap_sel_word[mtdl_pkg::GAIN_W +: mtdl_pkg::DELAY_W];
    assign tap_use      = tap_sel_word[mtdl_pkg::TAP_ACTIVE_BIT] && (tap_delay != '0)
                          && (32'(tap_delay) <= mtdl_pkg::DEPTH_FRAMES);

    always_comb begin
        frame_diff = DIFF_W'(frame_reg) - DIFF_W'(tap_delay);
        if (frame_diff < 0) begin
            frame_diff = frame_diff + DIFF_W'(mtdl_pkg::DEPTH_FRAMES);
        end
        read_frame = frame_diff[mtdl_pkg::FRAME_W-1:0];
    end

    assign sel_frame = cmd.store_write ? frame_reg : read_frame;
    assign item_addr = mtdl_pkg::ADDR_W'(sel_frame) * mtdl_pkg::ADDR_W'(cc_eff)
                       + mtdl_pkg::ADDR_W'(ch_eff);

    assign ram_en    = cmd.clr_write | cmd.store_write | cmd.tap_read;
    assign ram_we    = cmd.clr_write | cmd.store_write;
    assign ram_addr  = cmd.clr_write ? clr_cnt_reg : item_addr;
    assign ram_wdata = cmd.clr_write ? '0 : sample_reg;

    mtdl_ram #(
        .WIDTH (mtdl_pkg::SAMPLE_W),
        .DEPTH (mtdl_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign acc_init = {{(mtdl_pkg::ACC_W - mtdl_pkg::SAMPLE_W - mtdl_pkg::FRAC_W)
                        {sample_reg[mtdl_pkg::SAMPLE_W-1]}},
                       sample_reg, mtdl_pkg::FRAC_W'(0)};

    assign acc_rounded = acc_reg + mtdl_pkg::ACC_W'(mtdl_pkg::ROUND_BIAS);
    assign acc_scaled  = acc_rounded >>> mtdl_pkg::FRAC_W;
    assign fits = (acc_scaled[mtdl_pkg::ACC_W-1:mtdl_pkg::SAMPLE_W-1] == '0)
                  || (acc_scaled[mtdl_pkg::ACC_W-1:mtdl_pkg::SAMPLE_W-1] == '1);
    assign sat_out = fits ? acc_scaled[mtdl_pkg::SAMPLE_W-1:0]
                   : {acc_scaled[mtdl_pkg::ACC_W-1],
                      {(mtdl_pkg::SAMPLE_W-1){~acc_scaled[mtdl_pkg::ACC_W-1]}}};

    assign stat.clr_last = (clr_cnt_reg == mtdl_pkg::ADDR_W'(mtdl_pkg::STORE_DEPTH - 1));
    assign stat.out_free = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mtdl_pkg::NUM_TAPS; i++) begin
                tap_reg[i] <= '0;
            end
            chan_cnt_reg <= mtdl_pkg::CNT_W'(1);
            frame_reg    <= '0;
            chan_idx_reg <= '0;
            clr_cnt_reg  <= '0;
            rd_use_reg   <= 1'b0;
            prod_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (32'(cfg_index) < mtdl_pkg::NUM_TAPS) begin
                    tap_reg[mtdl_pkg::TAP_IDX_W'(cfg_index)] <= cfg_data;
                end else if (cfg_index ==
                             mtdl_pkg::CFG_IDX_W'(mtdl_pkg::REG_CHANNEL_COUNT)) begin
                    chan_cnt_reg <= cfg_data[mtdl_pkg::CNT_W-1:0];
                end
            end
            if (cmd.clr_write) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rd_use_reg <= cmd.tap_read & tap_use;
            if (rd_use_reg) begin
                prod_reg <= signed'(ram_rdata) * rd_gain_reg;
            end else begin
                prod_reg <= '0;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
                if (last_ch) begin
                    chan_idx_reg <= '0;
                    frame_reg    <= (frame_reg ==
                                     mtdl_pkg::FRAME_W'(mtdl_pkg::DEPTH_FRAMES - 1))
                                    ? '0 : frame_reg + 1'b1;
                end else begin
                    chan_idx_reg <= ch_eff + 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata;
        end
        rd_gain_reg <= tap_sel_word[mtdl_pkg::GAIN_W-1:0];
        if (cmd.store_write) begin
            acc_reg <= acc_init;
        end else begin
            acc_reg <= acc_reg + {{(mtdl_pkg::ACC_W - mtdl_pkg::PROD_W)
                                   {prod_reg[mtdl_pkg::PROD_W-1]}}, prod_reg};
        end
        if (cmd.load_out) begin
            m_tdata_reg <= sat_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/multi_tap_delay_line_unit.sv */
// Multi-tap audio delay line, top level.
// Depends on mtdl_pkg, mtdl_ctrl, mtdl_datapath (which holds mtdl_ram).
//
// Each accepted sample is written into a single-port delay store and then the
// four taps are read from the same port one after another, multiplied by their
// gains and summed with the dry sample; the rounded, saturated result lands in
// an output register. Each item runs through a store write, one read per tap,
// a multiply/accumulate drain and the result load; only then does the controller
// return to idle and take the next request. A new sample may be accepted while
// the previous result still waits on m_tready; the load of its result then
// waits until that previous result is taken, which stretches the item by that
// wait. After reset the store is swept to zero, one entry per cycle, over all
// DEPTH_FRAMES * MAX_CHANNELS = 65536 entries; s_tready stays low during that
// sweep while configuration writes are taken as usual.
module multi_tap_delay_line_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] sample_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [15:0] sample_out
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtdl_pkg::TAP_W-1:0]       cfg_data
);

    mtdl_pkg::dp_cmd_t  cmd;
    mtdl_pkg::dp_stat_t stat;

    mtdl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtdl_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/multi_tap_delay_line_unit_sva.sv */
// Port-level checker for the multi-tap delay line, bound to the top level.
// Depends on multi_tap_delay_line_unit_defines.svh.
`include "multi_tap_delay_line_unit_defines.svh"

module multi_tap_delay_line_unit_sva (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `MTDLU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result request dropped or changed while stalled")
    `MTDLU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready ##1 !s_tready, "input ready again while a request is in work")
    `MTDLU_ASSERT_NOW(a_clear_after_reset, $rose(aresetn), !s_tready, "input ready during store clear")
    `MTDLU_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

endmodule

bind multi_tap_delay_line_unit multi_tap_delay_line_unit_sva u_sva (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for multi_tap_delay_line_unit: directed dry path, tap, saturation and
// channel cases, then randomized traffic, all checked by an in-bench echo predictor.
// Depends on mtdl_pkg and the RTL of the delay line.
module tb_top;

    import mtdl_pkg::*;

    typedef logic [TAP_W-1:0] tap_word_t;

    localparam int          REG_SPARE      = REG_CHANNEL_COUNT + 1;
    localparam int          REG_TOP        = (1 << CFG_IDX_W) - 1;
    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          WATCHDOG_LIMIT = 262144;
    localparam logic [15:0] SAMPLE_MAX     = 16'h7FFF;
    localparam logic [15:0] SAMPLE_MIN     = 16'h8000;
    localparam logic [15:0] GAIN_ONE       = 16'h4000;
    localparam logic [15:0] GAIN_MINUS_ONE = 16'hC000;
    localparam logic [15:0] GAIN_MAX       = 16'h7FFF;
    localparam logic [15:0] GAIN_MIN       = 16'h8000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TAP_W-1:0]     cfg_data;

    // echo predictor state
    bit [TAP_W-1:0]    tap_shadow [NUM_TAPS];
    bit [CNT_W-1:0]    chan_shadow = CNT_W'(1);
    bit [SAMPLE_W-1:0] echo_store [STORE_DEPTH];
    bit [FRAME_W-1:0]  cur_frame;
    bit [CH_W-1:0]     cur_chan;

    logic [SAMPLE_W-1:0] expected_mix [$];
    logic [SAMPLE_W-1:0] want_mix;
    int                  fail_count;
    int                  quiet_cycles;
    int unsigned         src_gap_max    = 6;
    int unsigned         sink_stall_max = 6;

    tap_word_t tap_plan [NUM_TAPS];
    tap_word_t chan_plan;

    multi_tap_delay_line_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned used_channels();
        if (chan_shadow == 0) return 1;
        if (int'(chan_shadow) > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(chan_shadow);
    endfunction

    function automatic void predict_echo(input logic [SAMPLE_W-1:0] smp);
        int unsigned        ncnt;
        int unsigned        chn;
        int unsigned        dly;
        int unsigned        rpos;
        logic signed [15:0] dry;
        logic signed [15:0] gain;
        logic signed [15:0] past;
        longint             acc;
        longint             mix;
        ncnt = used_channels();
        chn  = cur_chan;
        if (chn >= ncnt) chn = 0;
        echo_store[int'(cur_frame) * ncnt + chn] = smp;
        dry = smp;
        acc = longint'(dry) * (longint'(1) << FRAC_W);
        for (int k = 0; k < NUM_TAPS; k++) begin
            dly = tap_shadow[k][31:16];
            if (tap_shadow[k][TAP_ACTIVE_BIT] && dly != 0 && dly <= DEPTH_FRAMES) begin
                rpos = ((int'(cur_frame) + DEPTH_FRAMES - dly) % DEPTH_FRAMES) * ncnt + chn;
                gain = tap_shadow[k][15:0];
                past = echo_store[rpos];
                acc  = acc + longint'(past) * longint'(gain);
            end
        end
        mix = (acc + ROUND_BIAS) >>> FRAC_W;
        if (mix > 32767) mix = 32767;
        else if (mix < -32768) mix = -32768;
        expected_mix.push_back(mix[SAMPLE_W-1:0]);
        if (chn + 1 >= ncnt) begin
            cur_chan  = '0;
            cur_frame = cur_frame + 1'b1;
        end else begin
            cur_chan = CH_W'(chn + 1);
        end
    endfunction

    function automatic void apply_reg(input int unsigned idx, input tap_word_t val);
        if (idx < NUM_TAPS) tap_shadow[idx] = val;
        else if (idx == REG_CHANNEL_COUNT) chan_shadow = val[CNT_W-1:0];
    endfunction

    function automatic tap_word_t make_tap(input bit active, input int unsigned dly,
                                           input logic [15:0] gain);
        return {active, dly[DELAY_W-1:0], gain};
    endfunction

    function automatic int unsigned pick_delay();
        int unsigned r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 24);
        if (r < 78) return 0;
        if (r < 86) return DEPTH_FRAMES;
        if (r < 93) return $urandom_range(DEPTH_FRAMES + 1, 65535);
        return $urandom_range(1, DEPTH_FRAMES - 1);
    endfunction

    function automatic logic [15:0] pick_gain();
        if ($urandom_range(0, 1) == 1) return 16'($urandom);
        return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 31))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        predict_echo(smp);
        @(negedge aclk);
    endtask

    task automatic write_reg(input int unsigned idx, input tap_word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic program_regs(input bit with_spare);
        for (int k = 0; k < NUM_TAPS; k++) write_reg(k, tap_plan[k]);
        write_reg(REG_CHANNEL_COUNT, chan_plan);
        if (with_spare) begin
            write_reg(REG_SPARE, TAP_W'({$urandom, $urandom}));
            write_reg(REG_TOP, TAP_W'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic randomize_setting();
        for (int k = 0; k < NUM_TAPS; k++)
            tap_plan[k] = make_tap($urandom_range(0, 99) < 85, pick_delay(), pick_gain());
        chan_plan = TAP_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
            chan_plan[TAP_W-1:CNT_W] = (TAP_W - CNT_W)'({$urandom, $urandom});
    endtask

    task automatic test_dry_path();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain_results();
    endtask

    task automatic test_tap_cases();
        // inactive, zero delay and delay past the store add nothing
        tap_plan[0] = make_tap(1'b1, 1, GAIN_ONE);
        tap_plan[1] = make_tap(1'b1, 0, GAIN_MAX);
        tap_plan[2] = make_tap(1'b0, 1, GAIN_MAX);
        tap_plan[3] = make_tap(1'b1, DEPTH_FRAMES + 1, GAIN_MAX);
        chan_plan   = TAP_W'(1);
        program_regs(1'b1);
        send_sample(16'h1000);
        send_sample(16'hF830);
        send_sample(SAMPLE_MAX);
        drain_results();
        // full-depth delay reads the request just written
        tap_plan[0] = make_tap(1'b1, DEPTH_FRAMES, GAIN_ONE);
        tap_plan[1] = make_tap(1'b1, 65535, GAIN_MAX);
        tap_plan[2] = make_tap(1'b1, DEPTH_FRAMES - 1, GAIN_MAX);
        tap_plan[3] = make_tap(1'b1, 2, GAIN_MIN);
        program_regs(1'b0);
        send_sample(16'h0100);
        send_sample(SAMPLE_MIN);
        send_sample(16'h3FFF);
        drain_results();
    endtask

    task automatic test_saturation();
        for (int k = 0; k < NUM_TAPS; k++) tap_plan[k] = make_tap(1'b1, DEPTH_FRAMES, GAIN_MAX);
        program_regs(1'b0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_results();
        for (int k = 0; k < NUM_TAPS; k++) tap_plan[k] = make_tap(1'b1, DEPTH_FRAMES, GAIN_MIN);
        program_regs(1'b0);
        send_sample(SAMPLE_MIN);
        drain_results();
    endtask

    task automatic test_channel_count();
        tap_plan[0] = make_tap(1'b1, 1, GAIN_ONE);
        tap_plan[1] = make_tap(1'b1, 2, GAIN_MINUS_ONE);
        tap_plan[2] = make_tap(1'b0, 0, 16'h0000);
        tap_plan[3] = make_tap(1'b0, 0, 16'h0000);
        chan_plan   = TAP_W'(2);
        program_regs(1'b0);
        send_sample(16'h1234);
        send_sample(16'hEDCB);
        send_sample(16'h0F0F);
        drain_results();
        // lower the count mid-frame
        chan_plan = TAP_W'(1);
        program_regs(1'b0);
        send_sample(16'h2222);
        send_sample(16'h3333);
        drain_results();
        chan_plan = TAP_W'(0);
        program_regs(1'b0);
        send_sample(16'h4444);
        send_sample(16'hC000);
        drain_results();
        chan_plan = {{(TAP_W - CNT_W){1'b1}}, 2'd3};
        program_regs(1'b0);
        send_sample(16'h7000);
        send_sample(16'h9000);
        send_sample(16'h0001);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 3) != 0) begin
                randomize_setting();
                program_regs($urandom_range(0, 7) == 0);
            end
            src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 6;
            sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            burst = $urandom_range(1, 80);
            repeat (burst) send_sample(pick_sample());
            sent += burst;
        end
        drain_results();
    endtask

    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mix.size() == 0) begin
                $display("%0t: unexpected sample_out, expected none, actual %0d",
                         $time, $signed(m_tdata));
                fail_count++;
            end else begin
                want_mix = expected_mix.pop_front();
                if (m_tdata !== want_mix) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, $signed(want_mix), $signed(m_tdata));
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no request moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_dry_path();
        test_tap_cases();
        test_saturation();
        test_channel_count();
        test_random_traffic();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
